// File: src/ght_pkg.sv
`timescale 1ns / 1ps
// ght_pkg: shared widths, operation and status codes and the result record
// for the generational handle table; no dependencies

package ght_pkg;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 9;

  localparam int DEF_SLOTS      = 256;
  localparam int DEF_GEN_BITS   = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd3;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic [VALUE_W-1:0]  found_value;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live_handles;
  } ght_result_t;

endpackage

// File: src/generational_handle_table_core.sv
`timescale 1ns / 1ps
// generational_handle_table_core: slot memory, request sequencer and
// next-free scan; depends on ght_pkg and ght_out_stage
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+-----------------
//  in_     | request   | in_operation, in_value, in_handle_id           | in_valid/in_stall
//  out_    | result    | out_new_handle, out_found_value, out_status,   | out_valid/out_stall
//          |           | out_live_handles                               |
//
// destroy, lookup and rejected requests pass through EXEC and DELIVER back to IDLE;
// a successful create also runs the upward scan for the next free slot, SCAN_RD then
// SCAN_CHK for each probe (one read of the slot memory per probe)
// after reset a clearing pass writes every slot with in_stall high
// one result register holds a finished result while out_stall is high; the
// sequencer waits before its next result until that register drains

module generational_handle_table_core #(
  parameter int SLOTS      = ght_pkg::DEF_SLOTS,
  parameter int GEN_BITS   = ght_pkg::DEF_GEN_BITS,
  parameter int VALUE_BITS = ght_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ght_pkg::OP_W-1:0]       in_operation,
  input  logic [ght_pkg::VALUE_W-1:0]    in_value,
  input  logic [ght_pkg::HANDLE_W-1:0]   in_handle_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ght_pkg::HANDLE_W-1:0]   out_new_handle,
  output logic [ght_pkg::VALUE_W-1:0]    out_found_value,
  output logic [ght_pkg::STATUS_W-1:0]   out_status,
  output logic [ght_pkg::LIVE_W-1:0]     out_live_handles
);

  localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW      = IW + 1;
  localparam int VB      = (VALUE_BITS < ght_pkg::VALUE_W) ? VALUE_BITS : ght_pkg::VALUE_W;
  localparam int ENTRY_W = GEN_BITS + VB;

  localparam logic [CW-1:0] SLOTS_C     = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT_C = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DELIVER
  } state_t;

  // slot memory: generation above, stored value below; zero value means free
  logic [ENTRY_W-1:0] slot_mem [SLOTS];
  logic [ENTRY_W-1:0] rd_q_r;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 next_free_r, next_free_nxt;
  logic [CW-1:0]                 live_cnt_r, live_cnt_nxt;
  logic [IW-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic [ght_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [VB-1:0]                 val_r, val_nxt;
  logic [IW-1:0]                 hidx_r, hidx_nxt;
  logic [GEN_BITS-1:0]           hgen_r, hgen_nxt;
  logic                          hok_r, hok_nxt;
  ght_pkg::ght_result_t          res_r, res_nxt;

  logic [63:0]                   in_hidx_wide;
  logic [IW-1:0]                 in_hidx;
  logic                          in_hok;
  logic                          in_take;

  logic [GEN_BITS-1:0]           ent_gen;
  logic [VB-1:0]                 ent_val;
  logic [GEN_BITS-1:0]           gen_inc;
  logic [GEN_BITS-1:0]           gen_new;
  logic [63:0]                   handle_wide;
  logic [CW-1:0]                 nf_inc;

  logic                          out_push;
  logic                          out_space;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // handle decode: slot index above GEN_BITS, generation below
  assign in_hidx_wide = 64'(in_handle_id) >> GEN_BITS;
  assign in_hidx      = in_hidx_wide[IW-1:0];
  assign in_hok       = (in_hidx_wide < 64'(SLOTS));

  assign ent_gen = rd_q_r[ENTRY_W-1:VB];
  assign ent_val = rd_q_r[VB-1:0];

  // generation bump skips zero
  assign gen_inc     = ent_gen + GEN_BITS'(1);
  assign gen_new     = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign handle_wide = (64'(next_free_r[IW-1:0]) << GEN_BITS) | 64'(gen_new);
  assign nf_inc      = next_free_r + CW'(1);

  always_comb begin
    case (state_r)
      ST_IDLE: begin
        if (in_operation == ght_pkg::OP_CREATE) begin
          rd_addr = next_free_r[IW-1:0];
        end else begin
          rd_addr = in_hidx;
        end
      end
      default: rd_addr = next_free_r[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= slot_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    next_free_nxt = next_free_r;
    live_cnt_nxt  = live_cnt_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    hidx_nxt      = hidx_r;
    hgen_nxt      = hgen_r;
    hok_nxt       = hok_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = clr_cnt_r;
    wr_data       = '0;
    out_push      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == LAST_SLOT_C) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          op_nxt    = in_operation;
          val_nxt   = in_value[VB-1:0];
          hidx_nxt  = in_hidx;
          hgen_nxt  = in_handle_id[GEN_BITS-1:0];
          hok_nxt   = in_hok;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = ght_pkg::STATUS_OK;
        state_nxt      = ST_DELIVER;
        case (op_r)
          ght_pkg::OP_CREATE: begin
            if (val_r == '0) begin
              res_nxt.status = ght_pkg::STATUS_NULL;
            end else if (next_free_r >= SLOTS_C || live_cnt_r >= SLOTS_C) begin
              res_nxt.status = ght_pkg::STATUS_FULL;
            end else begin
              wr_en              = 1'b1;
              wr_addr            = next_free_r[IW-1:0];
              wr_data            = {gen_new, val_r};
              live_cnt_nxt       = live_cnt_r + CW'(1);
              res_nxt.new_handle = handle_wide[ght_pkg::HANDLE_W-1:0];
              next_free_nxt      = nf_inc;
              if (nf_inc < SLOTS_C) begin
                state_nxt = ST_SCAN_RD;
              end
            end
          end
          ght_pkg::OP_DESTROY: begin
            if (hok_r && ent_val != '0 && ent_gen == hgen_r) begin
              wr_en        = 1'b1;
              wr_addr      = hidx_r;
              wr_data      = {ent_gen, {VB{1'b0}}};
              live_cnt_nxt = live_cnt_r - CW'(1);
              if (CW'(hidx_r) < next_free_r) begin
                next_free_nxt = CW'(hidx_r);
              end
            end else begin
              res_nxt.status = ght_pkg::STATUS_BAD;
            end
          end
          ght_pkg::OP_LOOKUP: begin
            if (hok_r && ent_val != '0 && ent_gen == hgen_r) begin
              res_nxt.found_value = ght_pkg::VALUE_W'(ent_val);
            end else begin
              res_nxt.status = ght_pkg::STATUS_BAD;
            end
          end
          default: res_nxt.status = ght_pkg::STATUS_BAD;
        endcase
        res_nxt.live_handles = ght_pkg::LIVE_W'(live_cnt_nxt);
      end

      // read issued this cycle at next_free, checked in the next
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (ent_val != '0) begin
          next_free_nxt = nf_inc;
          if (nf_inc < SLOTS_C) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_DELIVER;
          end
        end else begin
          state_nxt = ST_DELIVER;
        end
      end

      ST_DELIVER: begin
        if (out_space) begin
          out_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      next_free_r <= '0;
      live_cnt_r  <= '0;
      clr_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      live_cnt_r  <= live_cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      op_r        <= op_nxt;
      val_r       <= val_nxt;
      hidx_r      <= hidx_nxt;
      hgen_r      <= hgen_nxt;
      hok_r       <= hok_nxt;
      res_r       <= res_nxt;
    end
  end

  ght_out_stage u_out_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (out_push),
    .res              (res_r),
    .space            (out_space),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_handle   (out_new_handle),
    .out_found_value  (out_found_value),
    .out_status       (out_status),
    .out_live_handles (out_live_handles)
  );

endmodule

// File: src/ght_out_stage.sv
`timescale 1ns / 1ps
// ght_out_stage: result register between the table sequencer and the output
// channel; depends on ght_pkg for the result record

module ght_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  ght_pkg::ght_result_t              res,
  output logic                              space,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ght_pkg::HANDLE_W-1:0]      out_new_handle,
  output logic [ght_pkg::VALUE_W-1:0]       out_found_value,
  output logic [ght_pkg::STATUS_W-1:0]      out_status,
  output logic [ght_pkg::LIVE_W-1:0]        out_live_handles
);

  logic                 valid_r;
  logic                 valid_nxt;
  ght_pkg::ght_result_t data_r;

  // a new result may enter when the register is empty or being drained
  assign space = !valid_r || !out_stall;

  always_comb begin
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (push) begin
        data_r <= res;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_new_handle   = data_r.new_handle;
  assign out_found_value  = data_r.found_value;
  assign out_status       = data_r.status;
  assign out_live_handles = data_r.live_handles;

endmodule
